>>> hdl/ttu_pkg.sv
// Shared types, codes and constants of the Taylor series trig unit.
package ttu_pkg;

	localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
	localparam int TOL_W = 25;

	localparam logic [1:0] OP_SIN = 2'd0;
	localparam logic [1:0] OP_COS = 2'd1;
	localparam logic [1:0] OP_TAN = 2'd2;
	localparam logic [1:0] OP_COT = 2'd3;

	typedef enum logic [4:0] {
		CMD_NOP,
		CMD_LOAD,
		CMD_ARG_OP,
		CMD_ARG_DEN,
		CMD_ARG_NUM,
		CMD_SIN_MOD,
		CMD_FOLD,
		CMD_SQ,
		CMD_X2,
		CMD_ACC,
		CMD_TDIV,
		CMD_TNEXT,
		CMD_SAVE_DEN,
		CMD_SAVE_NUM,
		CMD_SWAP,
		CMD_TMOD,
		CMD_TMOD_SET,
		CMD_QDIV,
		CMD_OUT_SC,
		CMD_OUT_INF,
		CMD_OUT_Q
	} cmd_t;

	typedef struct packed {
		logic tan;
		logic div_busy;
		logic more;
		logic den_zero;
		logic x_lt_half;
	} status_t;

	function automatic logic [10:0] term_divisor(input logic [4:0] n);
		logic [10:0] a;
		logic [10:0] b;
		logic [21:0] p;
		a = {5'd0, n, 1'b0} + 11'd2;
		b = a + 11'd1;
		p = a * b;
		return p[10:0];
	endfunction

endpackage

>>> hdl/ttu_div.sv
// Restoring divider, one quotient bit per cycle, shared by all divisions.
module ttu_div #(
	parameter int DIVW = 53,
	parameter int VW = 27
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [DIVW-1:0]              dividend,
	input  logic [VW-1:0]                divisor,
	input  logic [$clog2(DIVW+1)-1:0]    steps,
	output logic                         busy,
	output logic [DIVW-1:0]              quot
);

	localparam int CW = $clog2(DIVW + 1);

	logic            busy_q;
	logic [CW-1:0]   cnt_q;
	logic [DIVW-1:0] quo_q;
	logic [VW-1:0]   rem_q;
	logic [VW-1:0]   div_q;
	logic [VW:0]     shifted;
	logic [VW:0]     trial;
	logic            ge;

	assign shifted = {rem_q, quo_q[DIVW-1]};
	assign trial = shifted - {1'b0, div_q};
	assign ge = shifted >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVW-2:0], ge};
			rem_q <= ge ? trial[VW-1:0] : shifted[VW-1:0];
		end
	end

	assign busy = busy_q;
	assign quot = quo_q;

endmodule

>>> hdl/ttu_dp.sv
// Datapath: argument reduction, series terms, quotient and result registers.
module ttu_dp #(
	parameter int MAX_TERMS = 12,
	parameter int FRAC_BITS = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ttu_pkg::cmd_t            cmd,
	output ttu_pkg::status_t         sts,
	input  logic [1:0]               req_type,
	input  logic signed [31:0]       angle,
	input  logic                     tol_we,
	input  logic [ttu_pkg::TOL_W-1:0] tol_data,
	output logic signed [31:0]       value,
	output logic                     infinite
);

	localparam int F = FRAC_BITS;
	localparam logic [63:0] PI_FX = (ttu_pkg::PI_Q60 + (64'd1 << (59 - F))) >> (60 - F);
	localparam logic [63:0] HALF_FX = (ttu_pkg::PI_Q60 + (64'd1 << (60 - F))) >> (61 - F);
	localparam logic [63:0] TWO_PI_FX = PI_FX << 1;
	localparam logic [63:0] ONE_FX = 64'd1 << F;
	localparam logic [63:0] TOL_RST = ONE_FX / 64'd1000;
	localparam int VW = F + 3;
	localparam int MW = F + 2;
	localparam int XW = F + 4;
	localparam int TW = F + 3;
	localparam int PW = TW + XW;
	localparam int SW = F + 5;
	localparam int DIVW = 2 * F + 5;
	localparam int CW = $clog2(DIVW + 1);
	localparam int NW = $clog2(MAX_TERMS + 1);
	localparam int RED_TOP = 32 - F;
	localparam int RJW = $clog2(RED_TOP + 1);
	localparam logic signed [33:0] HALF_A = 34'(HALF_FX);

	logic [1:0]               op_q;
	logic signed [32:0]       ang_q;
	logic signed [33:0]       arg_q;
	logic                     flip_q;
	logic [MW-1:0]            m_q;
	logic [XW-1:0]            x2_q;
	logic [TW-1:0]            term_q;
	logic [TW-1:0]            diff_q;
	logic signed [SW-1:0]     sum_q;
	logic                     negterm_q;
	logic [NW-1:0]            n_q;
	logic [PW-1:0]            prod_q;
	logic signed [SW-1:0]     den_q;
	logic signed [SW-1:0]     num_q;
	logic                     cot_q;
	logic                     neg_q;
	logic [ttu_pkg::TOL_W-1:0] tol_q;
	logic signed [31:0]       value_q;
	logic                     inf_q;
	logic [31:0]              red_q;
	logic [RJW-1:0]           red_j_q;
	logic                     red_busy_q;
	logic                     red_two_q;

	logic signed [33:0] ang_x;
	logic signed [33:0] ang_h;
	logic [33:0]        arg_mag;
	logic [33:0]        ang_mag;
	logic [SW-1:0]      num_mag;
	logic [SW-1:0]      den_mag;
	logic signed [SW-1:0] sres;
	logic signed [33:0] sres_x;
	logic signed [SW-1:0] term_s;
	logic [TW-1:0]      mul_a;
	logic [XW-1:0]      mul_b;
	logic [PW-1:0]      mul_p;
	logic [34:0]        red_sub;
	logic               div_start;
	logic [DIVW-1:0]    div_dividend;
	logic [VW-1:0]      div_divisor;
	logic [CW-1:0]      div_steps;
	logic               div_busy;
	logic [DIVW-1:0]    div_quot;
	logic               q_big;
	logic               q_neg;

	assign ang_x = 34'(ang_q);
	assign ang_h = ang_x + HALF_A;
	assign arg_mag = arg_q[33] ? 34'(-arg_q) : 34'(arg_q);
	assign ang_mag = ang_x[33] ? 34'(-ang_x) : 34'(ang_x);
	assign num_mag = num_q[SW-1] ? SW'(-num_q) : SW'(num_q);
	assign den_mag = den_q[SW-1] ? SW'(-den_q) : SW'(den_q);
	assign sres = flip_q ? -sum_q : sum_q;
	assign sres_x = 34'(sres);
	assign term_s = $signed(SW'(term_q));
	assign q_big = |div_quot[DIVW-1:31];
	assign q_neg = (num_q[SW-1] ^ den_q[SW-1]) ^ neg_q;

	assign mul_a = (cmd == ttu_pkg::CMD_SQ) ? TW'(m_q) : term_q;
	assign mul_b = (cmd == ttu_pkg::CMD_SQ) ? XW'(m_q) : x2_q;
	assign mul_p = mul_a * mul_b;

	assign red_sub = (red_two_q ? 35'(TWO_PI_FX) : 35'(PI_FX)) << red_j_q;

	always_comb begin
		div_start = 1'b0;
		div_dividend = '0;
		div_divisor = '0;
		div_steps = '0;
		case (cmd)
			ttu_pkg::CMD_TDIV: begin
				div_start = 1'b1;
				div_dividend = {prod_q[PW-1:F], {(DIVW-PW+F){1'b0}}};
				div_divisor = VW'(ttu_pkg::term_divisor(5'(n_q)));
				div_steps = CW'(PW - F);
			end
			ttu_pkg::CMD_QDIV: begin
				div_start = 1'b1;
				div_dividend = DIVW'(num_mag) << F;
				div_divisor = den_mag[VW-1:0];
				div_steps = CW'(DIVW);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	ttu_div #(
		.DIVW(DIVW),
		.VW(VW)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dividend),
		.divisor(div_divisor),
		.steps(div_steps),
		.busy(div_busy),
		.quot(div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= ttu_pkg::TOL_W'(TOL_RST);
		end else if (tol_we) begin
			tol_q <= tol_data;
		end
	end

	// subtract shifted multiples of the modulus, largest first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_busy_q <= 1'b0;
			red_j_q <= '0;
		end else if (cmd == ttu_pkg::CMD_SIN_MOD || cmd == ttu_pkg::CMD_TMOD) begin
			red_busy_q <= 1'b1;
			red_j_q <= RJW'(RED_TOP);
		end else if (red_busy_q) begin
			red_j_q <= red_j_q - RJW'(1);
			if (red_j_q == '0) begin
				red_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd == ttu_pkg::CMD_SIN_MOD) begin
			red_q <= arg_mag[31:0];
			red_two_q <= 1'b1;
		end else if (cmd == ttu_pkg::CMD_TMOD) begin
			red_q <= ang_mag[31:0];
			red_two_q <= 1'b0;
		end else if (red_busy_q && ({3'b000, red_q} >= red_sub)) begin
			red_q <= 32'({3'b000, red_q} - red_sub);
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			ttu_pkg::CMD_LOAD: begin
				op_q <= req_type;
				ang_q <= 33'(angle);
				cot_q <= (req_type == ttu_pkg::OP_COT);
				neg_q <= 1'b0;
			end
			ttu_pkg::CMD_ARG_OP: begin
				arg_q <= (op_q == ttu_pkg::OP_COS) ? ang_h : ang_x;
			end
			ttu_pkg::CMD_ARG_DEN: begin
				arg_q <= cot_q ? ang_x : ang_h;
			end
			ttu_pkg::CMD_ARG_NUM: begin
				arg_q <= cot_q ? ang_h : ang_x;
			end
			ttu_pkg::CMD_SIN_MOD: begin
				flip_q <= arg_q[33];
			end
			ttu_pkg::CMD_FOLD: begin
				if (red_q > PI_FX[31:0]) begin
					m_q <= MW'(red_q - PI_FX[31:0]);
					flip_q <= ~flip_q;
				end else begin
					m_q <= MW'(red_q);
				end
				sum_q <= '0;
				diff_q <= TW'(ONE_FX);
				n_q <= '0;
				negterm_q <= 1'b0;
			end
			ttu_pkg::CMD_SQ: begin
				prod_q <= mul_p;
			end
			ttu_pkg::CMD_X2: begin
				x2_q <= prod_q[F+XW-1:F];
				term_q <= TW'(m_q);
			end
			ttu_pkg::CMD_ACC: begin
				sum_q <= negterm_q ? sum_q - term_s : sum_q + term_s;
				diff_q <= term_q;
				prod_q <= mul_p;
			end
			ttu_pkg::CMD_TNEXT: begin
				term_q <= div_quot[TW-1:0];
				negterm_q <= ~negterm_q;
				n_q <= n_q + NW'(1);
			end
			ttu_pkg::CMD_SAVE_DEN: begin
				den_q <= sres;
			end
			ttu_pkg::CMD_SAVE_NUM: begin
				num_q <= sres;
			end
			ttu_pkg::CMD_SWAP: begin
				ang_q <= 33'(ang_x - HALF_A);
				cot_q <= ~cot_q;
				neg_q <= ~neg_q;
			end
			ttu_pkg::CMD_TMOD_SET: begin
				ang_q <= ang_q[32] ? -$signed(33'(red_q)) : $signed(33'(red_q));
			end
			ttu_pkg::CMD_OUT_SC: begin
				if (sres_x > 34'sh0_7FFF_FFFF) begin
					value_q <= 32'sh7FFF_FFFF;
				end else if (sres_x < -34'sh0_8000_0000) begin
					value_q <= 32'sh8000_0000;
				end else begin
					value_q <= 32'(sres_x);
				end
				inf_q <= 1'b0;
			end
			ttu_pkg::CMD_OUT_INF: begin
				value_q <= neg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
				inf_q <= 1'b1;
			end
			ttu_pkg::CMD_OUT_Q: begin
				if (q_big) begin
					value_q <= q_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
				end else begin
					value_q <= q_neg ? -$signed(div_quot[31:0]) : $signed(div_quot[31:0]);
				end
				inf_q <= 1'b0;
			end
			default: begin
				op_q <= op_q;
			end
		endcase
	end

	assign sts.tan = op_q[1];
	assign sts.div_busy = div_busy || red_busy_q;
	assign sts.more = (32'(diff_q) > 32'(tol_q)) && (n_q < NW'(MAX_TERMS));
	assign sts.den_zero = (den_q == '0);
	assign sts.x_lt_half = (ang_x < HALF_A);

	assign value = value_q;
	assign infinite = inf_q;

endmodule

>>> hdl/ttu_ctrl.sv
// Controller: sequences reduction, series loop, quadrant swap and division.
module ttu_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  ttu_pkg::status_t sts,
	output ttu_pkg::cmd_t    cmd
);

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DISP,
		ST_ARG_OP,
		ST_ARG_DEN,
		ST_ARG_NUM,
		ST_SN_MOD,
		ST_SN_MODW,
		ST_SN_FOLD,
		ST_SN_SQ,
		ST_SN_X2,
		ST_SN_CHK,
		ST_SN_ACC,
		ST_SN_TDIV,
		ST_SN_TDIVW,
		ST_SN_TNEXT,
		ST_SAVE_DEN,
		ST_DEN_CHK,
		ST_SAVE_NUM,
		ST_SWAP,
		ST_TMOD,
		ST_TMODW,
		ST_TMOD_SET,
		ST_QDIV,
		ST_QDIVW,
		ST_OUT_SC,
		ST_OUT_INF,
		ST_OUT_Q
	} state_t;

	typedef enum logic [1:0] {
		RET_OUT,
		RET_DEN,
		RET_NUM
	} ret_t;

	state_t state_q;
	ret_t   ret_q;
	logic   out_valid_q;
	logic   slot_free;
	logic   out_load;

	assign slot_free = !out_valid_q || !out_stall;
	assign out_load = (cmd == ttu_pkg::CMD_OUT_SC) || (cmd == ttu_pkg::CMD_OUT_INF) ||
		(cmd == ttu_pkg::CMD_OUT_Q);

	always_comb begin
		case (state_q)
			ST_IDLE:     cmd = in_valid ? ttu_pkg::CMD_LOAD : ttu_pkg::CMD_NOP;
			ST_ARG_OP:   cmd = ttu_pkg::CMD_ARG_OP;
			ST_ARG_DEN:  cmd = ttu_pkg::CMD_ARG_DEN;
			ST_ARG_NUM:  cmd = ttu_pkg::CMD_ARG_NUM;
			ST_SN_MOD:   cmd = ttu_pkg::CMD_SIN_MOD;
			ST_SN_FOLD:  cmd = ttu_pkg::CMD_FOLD;
			ST_SN_SQ:    cmd = ttu_pkg::CMD_SQ;
			ST_SN_X2:    cmd = ttu_pkg::CMD_X2;
			ST_SN_ACC:   cmd = ttu_pkg::CMD_ACC;
			ST_SN_TDIV:  cmd = ttu_pkg::CMD_TDIV;
			ST_SN_TNEXT: cmd = ttu_pkg::CMD_TNEXT;
			ST_SAVE_DEN: cmd = ttu_pkg::CMD_SAVE_DEN;
			ST_SAVE_NUM: cmd = ttu_pkg::CMD_SAVE_NUM;
			ST_SWAP:     cmd = ttu_pkg::CMD_SWAP;
			ST_TMOD:     cmd = ttu_pkg::CMD_TMOD;
			ST_TMOD_SET: cmd = ttu_pkg::CMD_TMOD_SET;
			ST_QDIV:     cmd = ttu_pkg::CMD_QDIV;
			ST_OUT_SC:   cmd = slot_free ? ttu_pkg::CMD_OUT_SC : ttu_pkg::CMD_NOP;
			ST_OUT_INF:  cmd = slot_free ? ttu_pkg::CMD_OUT_INF : ttu_pkg::CMD_NOP;
			ST_OUT_Q:    cmd = slot_free ? ttu_pkg::CMD_OUT_Q : ttu_pkg::CMD_NOP;
			default:     cmd = ttu_pkg::CMD_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q <= RET_OUT;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DISP;
					end
				end
				ST_DISP: begin
					state_q <= sts.tan ? ST_TMOD : ST_ARG_OP;
				end
				ST_ARG_OP: begin
					ret_q <= RET_OUT;
					state_q <= ST_SN_MOD;
				end
				ST_ARG_DEN: begin
					ret_q <= RET_DEN;
					state_q <= ST_SN_MOD;
				end
				ST_ARG_NUM: begin
					ret_q <= RET_NUM;
					state_q <= ST_SN_MOD;
				end
				ST_SN_MOD:  state_q <= ST_SN_MODW;
				ST_SN_MODW: begin
					if (!sts.div_busy) begin
						state_q <= ST_SN_FOLD;
					end
				end
				ST_SN_FOLD: state_q <= ST_SN_SQ;
				ST_SN_SQ:   state_q <= ST_SN_X2;
				ST_SN_X2:   state_q <= ST_SN_CHK;
				ST_SN_CHK: begin
					if (sts.more) begin
						state_q <= ST_SN_ACC;
					end else begin
						case (ret_q)
							RET_DEN: state_q <= ST_SAVE_DEN;
							RET_NUM: state_q <= ST_SAVE_NUM;
							default: state_q <= ST_OUT_SC;
						endcase
					end
				end
				ST_SN_ACC:  state_q <= ST_SN_TDIV;
				ST_SN_TDIV: state_q <= ST_SN_TDIVW;
				ST_SN_TDIVW: begin
					if (!sts.div_busy) begin
						state_q <= ST_SN_TNEXT;
					end
				end
				ST_SN_TNEXT: state_q <= ST_SN_CHK;
				ST_SAVE_DEN: state_q <= ST_DEN_CHK;
				ST_DEN_CHK: begin
					if (sts.den_zero) begin
						state_q <= ST_OUT_INF;
					end else if (sts.x_lt_half) begin
						state_q <= ST_ARG_NUM;
					end else begin
						state_q <= ST_SWAP;
					end
				end
				ST_SWAP: state_q <= ST_TMOD;
				ST_TMOD: state_q <= ST_TMODW;
				ST_TMODW: begin
					if (!sts.div_busy) begin
						state_q <= ST_TMOD_SET;
					end
				end
				ST_TMOD_SET: state_q <= ST_ARG_DEN;
				ST_SAVE_NUM: state_q <= ST_QDIV;
				ST_QDIV:     state_q <= ST_QDIVW;
				ST_QDIVW: begin
					if (!sts.div_busy) begin
						state_q <= ST_OUT_Q;
					end
				end
				ST_OUT_SC, ST_OUT_INF, ST_OUT_Q: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

>>> hdl/taylor_trig_unit_core.sv
// Top level of the Taylor series sine, cosine, tangent and cotangent unit.
// One request at a time. A sine or cosine sums at most MAX_TERMS series terms; each
// term costs one multiply and a bit-serial divide by (k+1)(k+2) in the shared divider,
// and the angle reduction is 33-FRAC_BITS compare and subtract steps against shifted
// multiples of the modulus. Tangent and cotangent run one to three series evaluations
// plus one or two such reductions and, unless the denominator is zero, a final quotient.
// A new request is taken while the last result waits.
module taylor_trig_unit_core #(
	parameter int MAX_TERMS = 12,
	parameter int FRAC_BITS = 24
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                req_type,
	input  logic signed [31:0]        angle,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [31:0]        value,
	output logic                      infinite,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [ttu_pkg::TOL_W-1:0] cfg_data
);

	ttu_pkg::cmd_t    cmd;
	ttu_pkg::status_t sts;

	assign cfg_ready = 1'b1;

	ttu_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts(sts),
		.cmd(cmd)
	);

	ttu_dp #(
		.MAX_TERMS(MAX_TERMS),
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.req_type(req_type),
		.angle(angle),
		.tol_we(cfg_valid && cfg_ready),
		.tol_data(cfg_data),
		.value(value),
		.infinite(infinite)
	);

`ifndef NO_ASSERTIONS
	a_accept_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request accepted without going busy");

	a_inf_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && infinite) |-> (value == 32'sh7FFF_FFFF || value == 32'sh8000_0000))
		else $error("infinite result not saturated");

	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == ttu_pkg::CMD_SIN_MOD || cmd == ttu_pkg::CMD_TMOD ||
		cmd == ttu_pkg::CMD_TDIV || cmd == ttu_pkg::CMD_QDIV) |-> !sts.div_busy)
		else $error("divider started while busy");
`endif

endmodule
